[rtl/mexp_pkg.sv]
package mexp_pkg;

    // operand and product widths
    localparam int OPERAND_WIDTH = 31;
    localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
    localparam int REM_CNT_W     = $clog2(PROD_WIDTH);
    localparam int STEP_W        = 4;

    typedef logic [OPERAND_WIDTH-1:0] t_word;
    typedef logic [PROD_WIDTH-1:0]    t_prod;
    typedef logic [STEP_W-1:0]        t_step;

    // datapath actions, one per control word
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_REM_BASE,
        DP_WR_B,
        DP_MUL_ACC,
        DP_MUL_SQ,
        DP_REM_PROD,
        DP_WR_ACC,
        DP_OUT
    } t_dp;

    // jump conditions: jump to target when true, else fall through
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_REQ,
        COND_REM_BUSY,
        COND_E_ZERO,
        COND_E_EVEN,
        COND_OUT_FULL
    } t_cond;

    typedef struct packed {
        logic  in_ready;
        t_dp   dp;
        logic  shift_e;
        t_cond cond;
        t_step target;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic rem_busy;
        logic e_zero;
        logic e_even;
        logic out_full;
    } t_stat;

    // program entry points
    localparam t_step STEP_IDLE     = 4'd0;
    localparam t_step STEP_BASE     = 4'd1;
    localparam t_step STEP_BASE_W   = 4'd2;
    localparam t_step STEP_BASE_WR  = 4'd3;
    localparam t_step STEP_LOOP     = 4'd4;
    localparam t_step STEP_BIT      = 4'd5;
    localparam t_step STEP_MUL      = 4'd6;
    localparam t_step STEP_MUL_R    = 4'd7;
    localparam t_step STEP_MUL_W    = 4'd8;
    localparam t_step STEP_MUL_WR   = 4'd9;
    localparam t_step STEP_SQ       = 4'd10;
    localparam t_step STEP_SQ_R     = 4'd11;
    localparam t_step STEP_SQ_W     = 4'd12;
    localparam t_step STEP_SQ_WR    = 4'd13;
    localparam t_step STEP_FINISH   = 4'd14;
    localparam t_step STEP_RESTART  = 4'd15;

    // microcode table
    function automatic t_ctrl ucode_rom(input t_step pc);
        t_ctrl w;
        w.in_ready = 1'b0;
        w.dp       = DP_NOP;
        w.shift_e  = 1'b0;
        w.cond     = COND_NEVER;
        w.target   = STEP_IDLE;
        case (pc)
            STEP_IDLE: begin
                w.in_ready = 1'b1;
                w.dp       = DP_LOAD;
                w.cond     = COND_NO_REQ;
                w.target   = STEP_IDLE;
            end
            STEP_BASE:    w.dp = DP_REM_BASE;
            STEP_BASE_W: begin
                w.cond   = COND_REM_BUSY;
                w.target = STEP_BASE_W;
            end
            STEP_BASE_WR: w.dp = DP_WR_B;
            STEP_LOOP: begin
                w.cond   = COND_E_ZERO;
                w.target = STEP_FINISH;
            end
            STEP_BIT: begin
                w.cond   = COND_E_EVEN;
                w.target = STEP_SQ;
            end
            STEP_MUL:     w.dp = DP_MUL_ACC;
            STEP_MUL_R:   w.dp = DP_REM_PROD;
            STEP_MUL_W: begin
                w.cond   = COND_REM_BUSY;
                w.target = STEP_MUL_W;
            end
            STEP_MUL_WR:  w.dp = DP_WR_ACC;
            STEP_SQ:      w.dp = DP_MUL_SQ;
            STEP_SQ_R:    w.dp = DP_REM_PROD;
            STEP_SQ_W: begin
                w.cond   = COND_REM_BUSY;
                w.target = STEP_SQ_W;
            end
            STEP_SQ_WR: begin
                w.dp      = DP_WR_B;
                w.shift_e = 1'b1;
                w.cond    = COND_ALWAYS;
                w.target  = STEP_LOOP;
            end
            STEP_FINISH: begin
                w.dp     = DP_OUT;
                w.cond   = COND_OUT_FULL;
                w.target = STEP_FINISH;
            end
            STEP_RESTART: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
            default: w.cond = COND_NEVER;
        endcase
        return w;
    endfunction

endpackage

[rtl/mexp_rem.sv]
module mexp_rem (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  mexp_pkg::t_prod       i_dividend,
    input  mexp_pkg::t_word       i_modulus,
    output logic                  o_busy,
    output mexp_pkg::t_word       o_rem
);
    import mexp_pkg::*;

    logic                 r_busy;
    logic [REM_CNT_W-1:0] r_cnt;
    t_prod                r_div;
    t_word                r_rem;
    t_word                r_mod;

    logic [OPERAND_WIDTH:0] s_trial;
    logic [OPERAND_WIDTH:0] s_diff;
    logic                   s_ge;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        s_trial = {r_rem, r_div[PROD_WIDTH-1]};
        s_ge    = (s_trial >= {1'b0, r_mod});
        s_diff  = s_ge ? (s_trial - {1'b0, r_mod}) : s_trial;
    end

    // control: run for one step per dividend bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= REM_CNT_W'(PROD_WIDTH - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_dividend;
            r_rem <= '0;
            r_mod <= i_modulus;
        end else if (r_busy) begin
            r_div <= {r_div[PROD_WIDTH-2:0], 1'b0};
            r_rem <= s_diff[OPERAND_WIDTH-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

    // start always raises busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("remainder unit not busy after start");

    // last step ends the run
    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt == '0) |=> !r_busy)
        else $error("remainder unit ran past last step");

    // finished remainder lies below the modulus
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && $past(r_busy) && $past(i_rst_n) && r_mod != '0) |-> (r_rem < r_mod))
        else $error("remainder not below modulus");

endmodule

[rtl/mexp_seq.sv]
module mexp_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mexp_pkg::t_stat i_stat,
    output mexp_pkg::t_ctrl o_ctrl
);
    import mexp_pkg::*;

    t_step r_pc;
    t_step n_pc;
    t_ctrl s_word;
    logic  s_take;

    // fetch the control word for the current step
    assign s_word = ucode_rom(r_pc);

    // evaluate the jump condition
    always_comb begin
        case (s_word.cond)
            COND_NEVER:    s_take = 1'b0;
            COND_ALWAYS:   s_take = 1'b1;
            COND_NO_REQ:   s_take = !i_stat.in_valid;
            COND_REM_BUSY: s_take = i_stat.rem_busy;
            COND_E_ZERO:   s_take = i_stat.e_zero;
            COND_E_EVEN:   s_take = i_stat.e_even;
            COND_OUT_FULL: s_take = i_stat.out_full;
            default:       s_take = 1'b0;
        endcase
        n_pc = s_take ? s_word.target : r_pc + 1'b1;
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = s_word;

endmodule

[rtl/modular_exponentiation.sv]
// flow: the accepted base is first reduced modulo the modulus, then for each exponent bit a zero bit
// squares and reduces the base, while a one bit first multiplies the accumulator by the base and
// reduces it, then squares; the remainder unit handles one dividend bit per cycle
// throughput: one request at a time; the next is taken only after the result is registered and the
// sequencer has passed its restart step back to the idle step
// reset: synchronous active low, clears the step counter, the remainder busy flag and the output valid
module modular_exponentiation (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  mexp_pkg::t_word       i_base,
    input  mexp_pkg::t_word       i_exponent,
    input  mexp_pkg::t_word       i_modulus,
    output logic                  o_valid,
    input  logic                  i_ready,
    output mexp_pkg::t_word       o_power_mod
);
    import mexp_pkg::*;

    t_ctrl s_ctrl;
    t_stat s_stat;
    logic  s_accept;
    logic  s_out_free;
    logic  s_rem_start;
    logic  s_rem_busy;
    t_word s_rem;
    t_prod s_rem_div;

    t_word r_acc;
    t_word r_b;
    t_word r_e;
    t_word r_m;
    t_prod r_prod;
    t_word r_out;
    logic  r_out_valid;

    assign s_accept    = s_ctrl.in_ready && i_valid;
    assign s_out_free  = !r_out_valid || i_ready;
    assign s_rem_start = (s_ctrl.dp == DP_REM_BASE) || (s_ctrl.dp == DP_REM_PROD);
    assign s_rem_div   = (s_ctrl.dp == DP_REM_BASE) ?
                         {{OPERAND_WIDTH{1'b0}}, r_b} : r_prod;

    // status back to the sequencer
    always_comb begin
        s_stat.in_valid = i_valid;
        s_stat.rem_busy = s_rem_busy;
        s_stat.e_zero   = (r_e == '0);
        s_stat.e_even   = !r_e[0];
        s_stat.out_full = !s_out_free;
    end

    mexp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (s_stat),
        .o_ctrl  (s_ctrl)
    );

    mexp_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_rem_start),
        .i_dividend (s_rem_div),
        .i_modulus  (r_m),
        .o_busy     (s_rem_busy),
        .o_rem      (s_rem)
    );

    // operand registers and multiplier
    always_ff @(posedge i_clk) begin
        case (s_ctrl.dp)
            DP_LOAD: begin
                if (s_accept) begin
                    r_b   <= i_base;
                    r_e   <= i_exponent;
                    r_m   <= i_modulus;
                    r_acc <= (i_modulus == OPERAND_WIDTH'(1)) ? '0 : OPERAND_WIDTH'(1);
                end
            end
            DP_WR_B:    r_b    <= s_rem;
            DP_WR_ACC:  r_acc  <= s_rem;
            DP_MUL_ACC: r_prod <= PROD_WIDTH'(r_acc) * PROD_WIDTH'(r_b);
            DP_MUL_SQ:  r_prod <= PROD_WIDTH'(r_b) * PROD_WIDTH'(r_b);
            default:    r_prod <= r_prod;
        endcase
        if (s_ctrl.shift_e) begin
            r_e <= r_e >> 1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_ctrl.dp == DP_OUT && s_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // a zero modulus gives zero
    always_ff @(posedge i_clk) begin
        if (s_ctrl.dp == DP_OUT && s_out_free) begin
            r_out <= (r_m == '0) ? '0 : r_acc;
        end
    end

    assign o_ready     = s_ctrl.in_ready;
    assign o_valid     = r_out_valid;
    assign o_power_mod = r_out;

    // an accepted request leaves the idle step
    a_accept_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !s_ctrl.in_ready)
        else $error("still ready after accepting a request");

    // the remainder unit is quiet while waiting for a request
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_ctrl.in_ready |-> !s_rem_busy)
        else $error("remainder unit busy while idle");

    // a finished result always lands in the output register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_ctrl.dp == DP_OUT && s_out_free) |=> r_out_valid)
        else $error("result not registered");

endmodule

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mexp_pkg::*;

    localparam t_word       WORD_MAX         = '1;
    localparam int          RANDOM_REQUESTS  = 300;
    localparam int          TAIL_REQUESTS    = 40;
    localparam int          DRAIN_AT         = 150;
    localparam int          LONG_HOLD_AFTER  = 40;
    localparam int          LONG_HOLD_CYCLES = 15000;
    localparam int          SETTLE_CYCLES    = 4500;
    localparam int unsigned CYCLE_LIMIT      = 6000000;

    // expected powers in request order, checked against the result port
    class power_scoreboard;
        t_word       expected_q[$];
        int unsigned requests;
        int unsigned results;
        int unsigned mismatches;

        function new();
            requests   = 0;
            results    = 0;
            mismatches = 0;
        endfunction

        // right-to-left square and multiply at 64-bit product width
        function t_word predict_power(input t_word b, input t_word e, input t_word m);
            logic [63:0] acc;
            logic [63:0] sq;
            logic [63:0] mm;
            t_word       bits;
            if (m == '0) begin
                return '0;
            end
            mm   = 64'(m);
            acc  = 64'd1 % mm;
            sq   = 64'(b) % mm;
            bits = e;
            while (bits != '0) begin
                if (bits[0]) begin
                    acc = (acc * sq) % mm;
                end
                sq   = (sq * sq) % mm;
                bits = bits >> 1;
            end
            return t_word'(acc);
        endfunction

        function void note_request(input t_word b, input t_word e, input t_word m);
            expected_q.push_back(predict_power(b, e, m));
            requests++;
        endfunction

        function void check_result(input t_word actual);
            t_word want;
            results++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d with no request pending: power_mod=%0d",
                             results, actual);
                end
                return;
            end
            want = expected_q.pop_front();
            if (actual !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d power_mod mismatch: expected %0d, got %0d",
                             results, want, actual);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic  i_clk      = 1'b0;
    logic  i_rst_n    = 1'b0;
    logic  i_valid    = 1'b0;
    logic  i_ready    = 1'b0;
    t_word i_base     = '0;
    t_word i_exponent = '0;
    t_word i_modulus  = t_word'(1);
    logic  o_ready;
    logic  o_valid;
    t_word o_power_mod;

    bit    quiet_tail = 1'b0;

    power_scoreboard sb = new();

    modular_exponentiation uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_base      (i_base),
        .i_exponent  (i_exponent),
        .i_modulus   (i_modulus),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_power_mod (o_power_mod)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // offer one request and hold it until the block takes it
    task automatic send_request(input t_word b, input t_word e, input t_word m);
        i_valid    <= 1'b1;
        i_base     <= b;
        i_exponent <= e;
        i_modulus  <= m;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(b, e, m);
    endtask

    // result capture
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_power_mod);
        end
    end

    // result side backpressure, with one long hold once results are flowing
    initial begin : result_sink
        int hold_left;
        bit long_hold_done;
        hold_left      = 0;
        long_hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!long_hold_done && sb.results >= LONG_HOLD_AFTER) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD_CYCLES - 1;
                i_ready        <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 14);
                i_ready   <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // run limit
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout with %0d results outstanding", sb.pending());
        $display("modular_exponentiation verification failed");
        $finish;
    end

    initial begin : stimulus
        t_word       b;
        t_word       e;
        t_word       m;
        int          n;
        int          k;
        int unsigned directed_count;

        // reset
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // modulus of one, including zero exponent
        send_request('0, '0, t_word'(1));
        send_request(WORD_MAX, WORD_MAX, t_word'(1));
        send_request(t_word'(5), '0, t_word'(1));
        // zero exponent and zero base
        send_request('0, '0, t_word'(7));
        send_request('0, t_word'(5), t_word'(7));
        send_request('0, WORD_MAX, WORD_MAX);
        send_request(WORD_MAX, '0, WORD_MAX);
        // full-width operands
        send_request(WORD_MAX, WORD_MAX, WORD_MAX);
        send_request(WORD_MAX - t_word'(1), WORD_MAX, WORD_MAX);
        send_request(WORD_MAX, WORD_MAX, WORD_MAX - t_word'(1));
        send_request(t_word'(1), WORD_MAX, WORD_MAX);
        send_request(WORD_MAX, WORD_MAX, t_word'(3));
        send_request(WORD_MAX, t_word'(2), t_word'(2));
        // base equal to and above the modulus
        send_request(t_word'(16), '0, t_word'(16));
        send_request(t_word'(16), t_word'(3), t_word'(16));
        send_request(t_word'(1000), t_word'(3), t_word'(7));
        // ordinary values
        send_request(t_word'(3), t_word'(1), t_word'(7));
        send_request(t_word'(2), t_word'(30), WORD_MAX);
        send_request(t_word'(7), t_word'(13), t_word'(1) << 30);
        send_request(t_word'(123456789), WORD_MAX, t_word'(1000000007));
        send_request(t_word'(2), t_word'(1) << 30, t_word'(65521));
        directed_count = sb.requests;

        // random requests
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            // let everything drain once mid-run
            if (n == DRAIN_AT) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while (sb.pending() != 0);
            end
            if (n >= RANDOM_REQUESTS - TAIL_REQUESTS) begin
                quiet_tail = 1'b1;
            end

            case ($urandom_range(0, 5))
                0:       m = t_word'($urandom_range(1, 16));
                1:       m = t_word'(1) << $urandom_range(0, OPERAND_WIDTH - 1);
                2:       m = WORD_MAX - t_word'($urandom_range(0, 15));
                3:       m = t_word'($urandom_range(1, 65535));
                default: m = t_word'($urandom);
            endcase
            if (m == '0) begin
                m = t_word'(1);
            end

            case ($urandom_range(0, 7))
                0:       b = '0;
                1:       b = t_word'(1);
                2:       b = m;
                3:       b = m - t_word'(1);
                4:       b = WORD_MAX;
                default: b = t_word'($urandom);
            endcase

            // mostly short exponents to keep the run time down
            case ($urandom_range(0, 15))
                0, 1, 2, 3: e = t_word'($urandom);
                4:          e = WORD_MAX;
                default: begin
                    k = $urandom_range(0, 16);
                    e = t_word'($urandom) & ((t_word'(1) << k) - t_word'(1));
                end
            endcase

            send_request(b, e, m);
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
        end

        // wait for the last results, then watch for strays
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d requests (%0d directed corners, %0d random), checked %0d results",
                 sb.requests, directed_count, sb.requests - directed_count, sb.results);
        $display("mismatches %0d, results still outstanding %0d",
                 sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("modular_exponentiation verification clean");
        end else begin
            $display("modular_exponentiation verification failed");
        end
        $finish;
    end

endmodule
